>>> design/bdhc_pkg.sv
// shared types, constants and register indexes for the button debounce block
package bdhc_pkg;

    localparam int unsigned COUNTER_WIDTH_DEF = 32;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned DOWN_TIME_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_DELAY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRESSED_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOLD_ENABLED = 3'd4;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_DELAY_RST = 16'd50;

    typedef struct packed {
        logic raw_level;
    } t_req;

    typedef struct packed {
        logic                   is_pressed;
        logic                   just_pressed;
        logic                   just_released;
        logic                   click;
        logic                   hold_event;
        logic [DOWN_TIME_W-1:0] down_time;
    } t_rsp;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_delay;
        logic [CFG_DATA_W-1:0] hold_delay;
        logic [CFG_DATA_W-1:0] hold_interval;
        logic                  pressed_level;
        logic                  hold_enabled;
        logic                  rewire;
        logic                  rewire_level;
    } t_cfg;

endpackage

>>> design/bdhc_stream_if.sv
// valid/ready channel carrying one request or result payload
interface bdhc_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> design/bdhc_cfg_regs.sv
// configuration registers of the button debounce block
module bdhc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdhc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bdhc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output bdhc_pkg::t_cfg                     o_cfg
);
    logic [bdhc_pkg::CFG_DATA_W-1:0] r_debounce_delay;
    logic [bdhc_pkg::CFG_DATA_W-1:0] r_hold_delay;
    logic [bdhc_pkg::CFG_DATA_W-1:0] r_hold_interval;
    logic                            r_pressed_level;
    logic                            r_hold_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_delay <= bdhc_pkg::DEBOUNCE_DELAY_RST;
            r_hold_delay     <= '0;
            r_hold_interval  <= '0;
            r_pressed_level  <= 1'b0;
            r_hold_enabled   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdhc_pkg::CFG_IDX_DEBOUNCE_DELAY: r_debounce_delay <= i_cfg_data;
                bdhc_pkg::CFG_IDX_HOLD_DELAY:     r_hold_delay <= i_cfg_data;
                bdhc_pkg::CFG_IDX_HOLD_INTERVAL:  r_hold_interval <= i_cfg_data;
                bdhc_pkg::CFG_IDX_PRESSED_LEVEL:  r_pressed_level <= i_cfg_data[0];
                bdhc_pkg::CFG_IDX_HOLD_ENABLED:   r_hold_enabled <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.debounce_delay = r_debounce_delay;
        o_cfg.hold_delay     = r_hold_delay;
        o_cfg.hold_interval  = r_hold_interval;
        o_cfg.pressed_level  = r_pressed_level;
        o_cfg.hold_enabled   = r_hold_enabled;
        o_cfg.rewire         = i_cfg_we && (i_cfg_idx == bdhc_pkg::CFG_IDX_PRESSED_LEVEL);
        o_cfg.rewire_level   = i_cfg_data[0];
    end
endmodule

>>> design/bdhc_in_reg.sv
// input register holding one raw level request
module bdhc_in_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_raw,
    input  logic i_adv,
    output logic o_valid,
    output logic o_raw
);
    logic r_valid;
    logic r_raw;

    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_raw <= i_raw;
        end
    end

    assign o_valid = r_valid;
    assign o_raw   = r_raw;
endmodule

>>> design/bdhc_core.sv
// debounce, press/release, click and hold state update for one tick
module bdhc_core #(
    parameter int unsigned COUNTER_WIDTH = bdhc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_raw,
    input  bdhc_pkg::t_cfg i_cfg,
    output bdhc_pkg::t_rsp o_res
);
    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

    logic                     r_last_raw;
    logic                     r_stable_pressed;
    logic [COUNTER_WIDTH-1:0] r_unch;
    logic [COUNTER_WIDTH-1:0] r_down;
    logic                     r_hold_fired;
    logic [COUNTER_WIDTH-1:0] r_tsh;

    logic                     n_stable_pressed;
    logic [COUNTER_WIDTH-1:0] n_unch;
    logic [COUNTER_WIDTH-1:0] n_down;
    logic                     n_hold_fired;
    logic [COUNTER_WIDTH-1:0] n_tsh;

    logic                     raw_pressed;
    logic                     level_ok;
    logic [COUNTER_WIDTH-1:0] debounce_w;
    logic [COUNTER_WIDTH-1:0] hold_delay_w;
    logic [COUNTER_WIDTH-1:0] hold_interval_w;
    logic [COUNTER_WIDTH-1:0] tsh_inc;
    logic                     repeat_due;
    logic                     jp;
    logic                     jr;
    logic                     clk_ev;
    logic                     hold;

    always_comb begin
        debounce_w      = COUNTER_WIDTH'(i_cfg.debounce_delay);
        hold_delay_w    = COUNTER_WIDTH'(i_cfg.hold_delay);
        hold_interval_w = COUNTER_WIDTH'(i_cfg.hold_interval);
        raw_pressed     = (i_raw == i_cfg.pressed_level);

        if (i_raw != r_last_raw) begin
            n_unch = '0;
        end else if (r_unch == CNT_MAX) begin
            n_unch = r_unch;
        end else begin
            n_unch = r_unch + 1'b1;
        end

        if (r_hold_fired && (r_tsh != CNT_MAX)) begin
            tsh_inc = r_tsh + 1'b1;
        end else begin
            tsh_inc = r_tsh;
        end

        level_ok   = (n_unch > debounce_w);
        repeat_due = (i_cfg.hold_interval != '0) && (tsh_inc > hold_interval_w);

        n_stable_pressed = r_stable_pressed;
        n_down           = r_down;
        n_hold_fired     = r_hold_fired;
        n_tsh            = tsh_inc;
        jp               = 1'b0;
        jr               = 1'b0;
        clk_ev           = 1'b0;
        hold             = 1'b0;

        if (level_ok) begin
            if (r_stable_pressed != raw_pressed) begin
                n_stable_pressed = raw_pressed;
                n_hold_fired     = 1'b0;
                n_tsh            = '0;
                jp               = raw_pressed;
                jr               = !raw_pressed;
                clk_ev           = !raw_pressed &&
                                   ((r_down < hold_delay_w) || !i_cfg.hold_enabled);
            end else if (r_stable_pressed) begin
                n_down = n_unch - debounce_w;
                if ((i_cfg.hold_delay != '0) && (!r_hold_fired || repeat_due) &&
                    (n_down > hold_delay_w) && i_cfg.hold_enabled) begin
                    hold         = 1'b1;
                    n_hold_fired = 1'b1;
                    n_tsh        = '0;
                end
            end
        end

        o_res.is_pressed    = n_stable_pressed;
        o_res.just_pressed  = jp;
        o_res.just_released = jr;
        o_res.click         = clk_ev;
        o_res.hold_event    = hold;
        o_res.down_time     = bdhc_pkg::DOWN_TIME_W'(n_down);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw       <= 1'b1;
            r_stable_pressed <= 1'b0;
            r_unch           <= '0;
            r_down           <= '0;
            r_hold_fired     <= 1'b0;
            r_tsh            <= '0;
        end else if (i_cfg.rewire) begin
            r_last_raw       <= !i_cfg.rewire_level;
            r_stable_pressed <= 1'b0;
        end else if (i_adv) begin
            r_last_raw       <= i_raw;
            r_stable_pressed <= n_stable_pressed;
            r_unch           <= n_unch;
            r_down           <= n_down;
            r_hold_fired     <= n_hold_fired;
            r_tsh            <= n_tsh;
        end
    end

    a_click_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.click) |-> o_res.just_released)
        else $error("click without release");

    a_hold_while_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && o_res.hold_event) |-> (o_res.is_pressed && !o_res.just_pressed))
        else $error("hold event while not held down");

    a_change_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_cfg.rewire && (i_raw != r_last_raw)) |=> (r_unch == '0))
        else $error("level change did not clear the unchanged count");

    a_hold_rearms_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_cfg.rewire && hold) |=> (r_hold_fired && (r_tsh == '0)))
        else $error("hold event did not restart the repeat timer");
endmodule

>>> design/bdhc_out_reg.sv
// result register toward the receiver
module bdhc_out_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  bdhc_pkg::t_rsp i_res,
    input  logic           i_ready,
    output logic           o_valid,
    output bdhc_pkg::t_rsp o_res
);
    logic           r_valid;
    bdhc_pkg::t_rsp r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

>>> design/button_debounce_hold_click_unit.sv
// push button debouncer with press, release, click and hold repeat events
//
// i_req carries one request per millisecond tick with the sampled pin level.
// o_rsp returns exactly one result per request: the debounced pressed state,
// press/release/click/hold flags and the saturating down time.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must do so only while no request is in flight (not enforced by the
// block); writing pressed_level also resets the debounced state to released.
// a request accepted into the input register is processed by the core and
// its result is written to the result register once that register is free.
// throughput: one request per cycle while the receiver does not stall, set
// by the state update between the input register and the result register.
// reset (synchronous, active low) clears all counters, sets the state to
// released and loads the register defaults (debounce delay 50).
// when the receiver stalls, the result register holds its result and the
// input register holds one more request; i_req.ready then drops until the
// result is taken.
module button_debounce_hold_click_unit #(
    parameter int unsigned COUNTER_WIDTH = bdhc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bdhc_stream_if.sink                     i_req,
    bdhc_stream_if.source                   o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bdhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdhc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    bdhc_pkg::t_cfg cfg;
    bdhc_pkg::t_rsp core_res;
    bdhc_pkg::t_rsp out_res;
    logic           in_valid;
    logic           in_raw;
    logic           out_valid;
    logic           adv;

    assign adv = in_valid && (!out_valid || o_rsp.ready);

    bdhc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    bdhc_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_raw   (i_req.payload.raw_level),
        .i_adv   (adv),
        .o_valid (in_valid),
        .o_raw   (in_raw)
    );

    bdhc_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_raw   (in_raw),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    bdhc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_res   (core_res),
        .i_ready (o_rsp.ready),
        .o_valid (out_valid),
        .o_res   (out_res)
    );

    assign o_rsp.valid   = out_valid;
    assign o_rsp.payload = out_res;
endmodule

>>> test/button_event_check_pkg.sv
// scoreboard that predicts and checks the debounced button events, one per tick
`timescale 1ns / 100ps
package button_event_check_pkg;
    import bdhc_pkg::*;

    localparam int unsigned CNT_W = COUNTER_WIDTH_DEF;
    localparam int unsigned REPORT_MAX = 40;

    class button_event_scoreboard;
        logic [CFG_DATA_W-1:0] debounce_delay;
        logic [CFG_DATA_W-1:0] hold_delay;
        logic [CFG_DATA_W-1:0] hold_interval;
        logic                  pressed_level;
        logic                  hold_enabled;

        logic                  prev_raw;
        logic                  stable_down;
        logic                  hold_seen;
        logic [CNT_W-1:0]      quiet_ticks;
        logic [CNT_W-1:0]      down_ticks;
        logic [CNT_W-1:0]      since_hold;

        t_rsp                  expected_events[$];
        int unsigned           errors;

        function new();
            debounce_delay = DEBOUNCE_DELAY_RST;
            hold_delay = '0;
            hold_interval = '0;
            pressed_level = 1'b0;
            hold_enabled = 1'b0;
            prev_raw = 1'b1;
            stable_down = 1'b0;
            hold_seen = 1'b0;
            quiet_ticks = '0;
            down_ticks = '0;
            since_hold = '0;
            errors = 0;
        endfunction

        function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IDX_DEBOUNCE_DELAY: debounce_delay = data;
                CFG_IDX_HOLD_DELAY: hold_delay = data;
                CFG_IDX_HOLD_INTERVAL: hold_interval = data;
                CFG_IDX_PRESSED_LEVEL: begin
                    // rewiring drops the debounced state back to released
                    pressed_level = data[0];
                    prev_raw = ~data[0];
                    stable_down = 1'b0;
                end
                CFG_IDX_HOLD_ENABLED: hold_enabled = data[0];
                default: ;
            endcase
        endfunction

        function void note_tick(logic raw);
            logic raw_down;
            t_rsp ev;
            raw_down = (raw == pressed_level);
            ev = '0;
            quiet_ticks = (raw != prev_raw) ? '0 : bump(quiet_ticks);
            if (hold_seen) begin
                since_hold = bump(since_hold);
            end
            if (quiet_ticks > debounce_delay) begin
                if (stable_down != raw_down) begin
                    stable_down = raw_down;
                    hold_seen = 1'b0;
                    since_hold = '0;
                    if (raw_down) begin
                        ev.just_pressed = 1'b1;
                    end else begin
                        ev.just_released = 1'b1;
                        ev.click = (down_ticks < hold_delay) || !hold_enabled;
                    end
                end else if (stable_down) begin
                    down_ticks = quiet_ticks - debounce_delay;
                    if (hold_delay != 0 && hold_enabled && down_ticks > hold_delay &&
                        (!hold_seen || (hold_interval != 0 && since_hold > hold_interval))) begin
                        ev.hold_event = 1'b1;
                        hold_seen = 1'b1;
                        since_hold = '0;
                    end
                end
            end
            prev_raw = raw;
            ev.is_pressed = stable_down;
            ev.down_time = DOWN_TIME_W'(down_ticks);
            expected_events.push_back(ev);
        endfunction

        function void compare(string field, logic [DOWN_TIME_W-1:0] exp_v,
                              logic [DOWN_TIME_W-1:0] got_v);
            if (exp_v !== got_v) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("%0t: %s mismatch, expected %0h actual %0h",
                             $time, field, exp_v, got_v);
                end
            end
        endfunction

        function void check_events(t_rsp got);
            t_rsp ev;
            if (expected_events.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) begin
                    $display("%0t: unexpected result, expected none actual %0h", $time, got);
                end
                return;
            end
            ev = expected_events.pop_front();
            compare("is_pressed", ev.is_pressed, got.is_pressed);
            compare("just_pressed", ev.just_pressed, got.just_pressed);
            compare("just_released", ev.just_released, got.just_released);
            compare("click", ev.click, got.click);
            compare("hold_event", ev.hold_event, got.hold_event);
            compare("down_time", ev.down_time, got.down_time);
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction
    endclass

endpackage

>>> test/tb.sv
// testbench top for the button debounce unit: random ticks, settings and idling
`timescale 1ns / 100ps
module tb;
    import bdhc_pkg::*;
    import button_event_check_pkg::*;

    localparam int unsigned WATCHDOG_CYCLES = 5000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PHASE_TICKS = 180;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned HOLD_OFF_PHASE = 4;
    localparam int unsigned PAUSE_PHASE = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
    localparam logic [CFG_DATA_W-1:0] DELAY_MAX = 16'hFFFF;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bdhc_stream_if #(.t_payload(t_req)) req_ch ();
    bdhc_stream_if #(.t_payload(t_rsp)) rsp_ch ();

    button_event_scoreboard sb;
    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned long_holds_asked = 0;
    int unsigned long_holds_done = 0;
    int unsigned ticks_sent = 0;

    button_debounce_hold_click_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                sb.note_tick(req_ch.payload.raw_level);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                sb.check_events(rsp_ch.payload);
            end
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_holds_asked != long_holds_done) begin
                long_holds_done++;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
            end
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    task automatic send_tick(input logic raw);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload.raw_level <= raw;
        do @(posedge i_clk); while (!req_ch.ready);
        ticks_sent++;
    endtask

    task automatic send_run(input logic raw, input int unsigned n);
        repeat (n) send_tick(raw);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] dd, input logic [CFG_DATA_W-1:0] hd,
                                  input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] pl,
                                  input logic [CFG_DATA_W-1:0] he);
        write_reg(CFG_IDX_DEBOUNCE_DELAY, dd);
        write_reg(CFG_IDX_HOLD_DELAY, hd);
        write_reg(CFG_IDX_HOLD_INTERVAL, hi);
        write_reg(CFG_IDX_PRESSED_LEVEL, pl);
        write_reg(CFG_IDX_HOLD_ENABLED, he);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned phase);
        logic [CFG_DATA_W-1:0] dd, hd, hi, pl_word, he_word;
        logic                  raw;
        int unsigned           start, n, span, k;
        bit                    paused;
        dd = ($urandom_range(7) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(5));
        k = $urandom_range(9);
        hd = (k == 0) ? '0 : (k == 1) ? 16'($urandom()) : 16'($urandom_range(1, 12));
        k = $urandom_range(9);
        hi = (k < 2) ? '0 : (k == 2) ? 16'($urandom()) : 16'($urandom_range(1, 5));
        pl_word = 16'($urandom());
        he_word = 16'($urandom());
        if ($urandom_range(3) != 0) begin
            he_word[0] = 1'b1;
        end
        drain();
        apply_settings(dd, hd, hi, pl_word, he_word);
        case (phase % 4)
            0: begin snd_idle_pct = 0;  rcv_stall_pct <= 0;  end
            1: begin snd_idle_pct = 51; rcv_stall_pct <= 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct <= 51; end
            default: begin snd_idle_pct = 29; rcv_stall_pct <= 29; end
        endcase
        if (phase == HOLD_OFF_PHASE) begin
            long_holds_asked <= long_holds_asked + 1;
        end
        span = (hd > 16 ? 16 : hd) + 4 * (hi > 8 ? 8 : hi) + 8;
        raw = ~pl_word[0];
        paused = 1'b0;
        start = ticks_sent;
        while (ticks_sent - start < PHASE_TICKS) begin
            if (phase == PAUSE_PHASE && !paused && ticks_sent - start >= PHASE_TICKS / 2) begin
                paused = 1'b1;
                drain();
            end
            k = $urandom_range(9);
            if (k == 0) begin
                // pure bounce noise
                repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)));
                raw = ~raw;
                if (k == 1) begin
                    n = $urandom_range(1, dd + 1);
                end else if (raw == pl_word[0]) begin
                    n = dd + 1 + $urandom_range(span);
                end else begin
                    n = dd + 1 + $urandom_range(6);
                end
                send_run(raw, n);
            end
        end
    endtask

    initial begin
        logic [16:0] pattern_hold;
        logic [6:0]  pattern_click;
        sb = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        drain();

        // writes to unused indexes must change nothing
        write_reg(CFG_IDX_SPARE_LO, DELAY_MAX);
        write_reg(CFG_IDX_SPARE_HI, 16'h0001);
        apply_settings(16'd1, 16'd2, 16'd1, 16'hFFFF, 16'h0001);
        pattern_hold = 17'b0_0011_1000_1111_1110;
        for (int i = 0; i < 17; i++) begin
            send_tick(pattern_hold[i]);
        end
        drain();
        apply_settings(16'd0, 16'd0, 16'd0, 16'h0002, 16'h0000);
        pattern_click = 7'b011_0001;
        for (int i = 0; i < 7; i++) begin
            send_tick(pattern_click[i]);
        end
        drain();

        // widest settings: no level stays long enough to be accepted
        apply_settings(DELAY_MAX, DELAY_MAX, DELAY_MAX, 16'h0001, 16'h0001);
        send_run(1'b0, 2);
        send_run(1'b1, 20);
        send_run(1'b0, 10);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            random_phase(p);
        end
        drain();

        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
